[rtl/core/dlfg_pkg.sv]
// shared widths, register map and helpers for the delayed linear fade gain block
`timescale 1ns / 1ps
`default_nettype none

package dlfg_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int GAIN_W      = 16;
  localparam int GAIN_SHIFT  = 14;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * SAMPLE_BITS + GAIN_W + 7) / 8) * 8;

  // shared multiplier: a side takes a sample or the ramp span, b side a gain or a position
  localparam int MUL_A_W = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;

  // divider works on a dividend of two gain widths, one quotient bit per step
  localparam int DIV_W     = 2 * GAIN_W;
  localparam int DIV_CNT_W = $clog2(GAIN_W);

  // apb register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_START_GAIN   = 2'd0;
  localparam logic [1:0] REG_END_GAIN     = 2'd1;
  localparam logic [1:0] REG_DELAY_FRAMES = 2'd2;
  localparam logic [1:0] REG_FADE_FRAMES  = 2'd3;

  localparam logic [GAIN_W-1:0] RST_START_GAIN   = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0] RST_END_GAIN     = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0] RST_DELAY_FRAMES = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] RST_FADE_FRAMES  = GAIN_W'(1);

  localparam logic signed [MUL_W-1:0] SAT_HI =
    {{(MUL_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [MUL_W-1:0] SAT_LO = ~SAT_HI;

  // floor shift of a product, then clamp to a signed sample
  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0] sh;
    sh = p >>> GAIN_SHIFT;
    if (sh > SAT_HI) begin
      return SAT_HI[SAMPLE_BITS-1:0];
    end else if (sh < SAT_LO) begin
      return SAT_LO[SAMPLE_BITS-1:0];
    end
    return sh[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/delayed_linear_fade_gain_top.sv]
// delayed linear fade gain: stereo frame scaler with delay, linear ramp and hold phases
// sequence: ramp frames go through span multiply, the divider, gain, left multiply,
//   right multiply and saturate; other frames start at the left multiply
// throughput: set by the one-bit-per-cycle divider (16 steps) and one shared multiplier; a
//   new frame is taken only in idle, while the finished one waits in the output register
// reset (rst_ni low, asynchronous): control and configuration registers to their defaults, fade restarts at delay
`timescale 1ns / 1ps
`default_nettype none

module delayed_linear_fade_gain_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // input frames
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [dlfg_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // left_sample, right_sample
  input  wire  [0:0]                         s_axis_tuser,   // restart
  // output frames
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [dlfg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // left_out, right_out, gain_now
  output logic [0:0]                         m_axis_tuser,   // fade_done
  // configuration
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [dlfg_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [dlfg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dlfg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import dlfg_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_RAMP_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV       = 3'd2;
  localparam logic [2:0] ST_GAIN      = 3'd3;
  localparam logic [2:0] ST_LEFT_MUL  = 3'd4;
  localparam logic [2:0] ST_RIGHT_MUL = 3'd5;
  localparam logic [2:0] ST_SAT       = 3'd6;

  // fade phases
  localparam logic [1:0] PH_DELAY = 2'd0;
  localparam logic [1:0] PH_RAMP  = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  // configuration registers
  logic [GAIN_W-1:0] start_gain_q, end_gain_q, delay_frames_q, fade_frames_q;
  logic              cfg_wr;

  // fade tracking
  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] pos_q, pos_d;

  // sequencer and datapath
  logic [2:0]             state_q, state_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] left_q, right_q;
  logic [GAIN_W-1:0]      gain_q, gain_d;
  logic [GAIN_W-1:0]      span_q;       // |end - start|
  logic                   span_neg_q;
  logic [GAIN_W-1:0]      ramp_pos_q;
  logic                   done_q, done_d;
  logic [DIV_W-1:0]       div_q, div_d;
  logic signed [MUL_W-1:0] prod_q;
  logic [SAMPLE_BITS-1:0] left_res_q;

  // output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_left_q, out_right_q;
  logic [GAIN_W-1:0]      out_gain_q;
  logic                   out_done_q;

  logic in_xfer, out_xfer, out_load;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_gain_q   <= RST_START_GAIN;
      end_gain_q     <= RST_END_GAIN;
      delay_frames_q <= RST_DELAY_FRAMES;
      fade_frames_q  <= RST_FADE_FRAMES;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_START_GAIN:   start_gain_q   <= pwdata[GAIN_W-1:0];
        REG_END_GAIN:     end_gain_q     <= pwdata[GAIN_W-1:0];
        REG_DELAY_FRAMES: delay_frames_q <= pwdata[GAIN_W-1:0];
        REG_FADE_FRAMES:  fade_frames_q  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_START_GAIN:   prdata[GAIN_W-1:0] = start_gain_q;
      REG_END_GAIN:     prdata[GAIN_W-1:0] = end_gain_q;
      REG_DELAY_FRAMES: prdata[GAIN_W-1:0] = delay_frames_q;
      REG_FADE_FRAMES:  prdata[GAIN_W-1:0] = fade_frames_q;
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  // last state may hand over once the output register is free or draining
  assign out_load      = (state_q == ST_SAT) && (!out_valid_q || m_axis_tready);

  // ---------------------------------------------------------------- phase update on transfer
  logic [1:0]            ph0, ph1, ph2;
  logic [COUNT_BITS-1:0] p0, p1, p2;

  always_comb begin
    // restart goes back to the delay phase with this frame
    ph0 = s_axis_tuser[0] ? PH_DELAY : phase_q;
    p0  = s_axis_tuser[0] ? '0 : pos_q;
    // delay over, enter the ramp
    if ((ph0 == PH_DELAY) && (p0 >= delay_frames_q)) begin
      ph1 = PH_RAMP;
      p1  = '0;
    end else begin
      ph1 = ph0;
      p1  = p0;
    end
    // ramp over, hold end gain
    if ((ph1 == PH_RAMP) && (p1 >= fade_frames_q)) begin
      ph2 = PH_DONE;
      p2  = '0;
    end else begin
      ph2 = ph1;
      p2  = p1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    if (in_xfer) begin
      phase_d = ph2;
      if ((ph2 == PH_DELAY) || (ph2 == PH_RAMP)) begin
        pos_d = p2 + 1'b1;
      end else begin
        pos_d = p2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELAY;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_W-1:0]   mul_p;

  always_comb begin
    case (state_q)
      ST_RAMP_MUL: begin
        mul_a = $signed(MUL_A_W'(span_q));
        mul_b = $signed({1'b0, ramp_pos_q});
      end
      ST_RIGHT_MUL: begin
        mul_a = MUL_A_W'($signed(right_q));
        mul_b = $signed({1'b0, gain_q});
      end
      default: begin
        mul_a = MUL_A_W'($signed(left_q));
        mul_b = $signed({1'b0, gain_q});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------- divider step
  // restoring division by fade_frames; quotient fits one gain width since the
  // ramp position stays below fade_frames
  logic [GAIN_W:0]   div_trial;
  logic              div_ge;
  logic [GAIN_W:0]   div_rem;

  always_comb begin
    div_trial = {div_q[DIV_W-1:GAIN_W], div_q[GAIN_W-1]};
    div_ge    = div_trial >= {1'b0, fade_frames_q};
    div_rem   = div_ge ? (div_trial - {1'b0, fade_frames_q}) : div_trial;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    div_d   = div_q;
    gain_d  = gain_q;
    done_d  = done_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (ph2 == PH_DELAY) begin
            gain_d  = start_gain_q;
            done_d  = 1'b0;
            state_d = ST_LEFT_MUL;
          end else if (ph2 == PH_RAMP) begin
            done_d  = 1'b0;
            state_d = ST_RAMP_MUL;
          end else begin
            // done, and the unused phase code
            gain_d  = end_gain_q;
            done_d  = 1'b1;
            state_d = ST_LEFT_MUL;
          end
        end
      end
      ST_RAMP_MUL: begin
        // span times position goes straight into the dividend
        cnt_d   = '0;
        div_d   = mul_p[DIV_W-1:0];
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_d = {div_rem[GAIN_W-1:0], div_q[GAIN_W-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(GAIN_W - 1)) begin
          state_d = ST_GAIN;
        end
      end
      ST_GAIN: begin
        // truncation toward zero: apply the magnitude quotient with the span's sign
        gain_d  = span_neg_q ? (start_gain_q - div_q[GAIN_W-1:0])
                             : (start_gain_q + div_q[GAIN_W-1:0]);
        state_d = ST_LEFT_MUL;
      end
      ST_LEFT_MUL: begin
        state_d = ST_RIGHT_MUL;
      end
      ST_RIGHT_MUL: begin
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    gain_q <= gain_d;
    done_q <= done_d;
    if (in_xfer) begin
      left_q     <= s_axis_tdata[SAMPLE_BITS-1:0];
      right_q    <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      ramp_pos_q <= GAIN_W'(p2);
      span_neg_q <= end_gain_q < start_gain_q;
      span_q     <= (end_gain_q < start_gain_q) ? (start_gain_q - end_gain_q)
                                                : (end_gain_q - start_gain_q);
    end
    if ((state_q == ST_LEFT_MUL) || (state_q == ST_RIGHT_MUL)) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_RIGHT_MUL) begin
      left_res_q <= sat_sample(prod_q);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= left_res_q;
      out_right_q <= sat_sample(prod_q);
      out_gain_q  <= gain_q;
      out_done_q  <= done_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[SAMPLE_BITS-1:0]                        = out_left_q;
    m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]            = out_right_q;
    m_axis_tdata[2*SAMPLE_BITS+GAIN_W-1:2*SAMPLE_BITS]   = out_gain_q;
    m_axis_tuser[0] = out_done_q;
  end

endmodule

`default_nettype wire

[tb/sv/tb_delayed_linear_fade_gain_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the delayed linear fade gain block
module tb_delayed_linear_fade_gain_top;
  import dlfg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES      = 16;
  localparam int FRAMES_PER_PHASE = 108;
  localparam int REPORT_MAX       = 10;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int TAIL_CYCLES      = 30;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0] FIELD_MAX  = '1;

  typedef enum logic [1:0] {PH_DELAY, PH_RAMP, PH_DONE} fade_phase_e;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          restart;
  } stereo_frame_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic [GAIN_W-1:0]      gain;
    logic                   done;
  } faded_frame_t;

  // block ports
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;  // left_sample, right_sample
  logic [0:0]              s_axis_tuser  = '0;  // restart
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;        // left_out, right_out, gain_now
  logic [0:0]              m_axis_tuser;        // fade_done
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr         = '0;
  logic [APB_DATA_W-1:0]   pwdata        = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // predictor copy of registers and fade state
  logic [GAIN_W-1:0]       start_cfg  = RST_START_GAIN;
  logic [GAIN_W-1:0]       end_cfg    = RST_END_GAIN;
  logic [GAIN_W-1:0]       delay_cfg  = RST_DELAY_FRAMES;
  logic [GAIN_W-1:0]       fade_cfg   = RST_FADE_FRAMES;
  fade_phase_e             fade_phase = PH_DELAY;
  logic [COUNT_BITS-1:0]   frame_pos  = '0;

  stereo_frame_t pending_frames[$];
  faded_frame_t  expected_frames[$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_req       = 0;
  int          hold_ack       = 0;
  int          hold_left      = 0;
  int          mismatch_count = 0;
  int          result_count   = 0;
  int unsigned cycle_count    = 0;

  delayed_linear_fade_gain_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor shift by the gain fraction, then clamp to a signed sample
  function automatic logic [SAMPLE_BITS-1:0] scale_by_gain(
    input logic signed [SAMPLE_BITS-1:0] s, input logic [GAIN_W-1:0] g);
    longint prod;
    longint hi;
    longint lo;
    hi   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo   = -hi - 1;
    prod = (longint'(s) * longint'(g)) >>> GAIN_SHIFT;
    if (prod > hi) begin
      prod = hi;
    end else if (prod < lo) begin
      prod = lo;
    end
    return prod[SAMPLE_BITS-1:0];
  endfunction

  // advances the fade state by one frame and returns the scaled frame
  function automatic faded_frame_t fade_gain_predict(input stereo_frame_t f);
    faded_frame_t      r;
    longint            span;
    longint            ramp_step;
    logic [GAIN_W-1:0] gain;
    if (f.restart) begin
      fade_phase = PH_DELAY;
      frame_pos  = '0;
    end
    // phase changes are checked against the current register values
    if (fade_phase == PH_DELAY && frame_pos >= delay_cfg) begin
      fade_phase = PH_RAMP;
      frame_pos  = '0;
    end
    if (fade_phase == PH_RAMP && frame_pos >= fade_cfg) begin
      fade_phase = PH_DONE;
      frame_pos  = '0;
    end
    r.done = 1'b0;
    case (fade_phase)
      PH_DELAY: begin
        gain      = start_cfg;
        frame_pos = frame_pos + 1'b1;
      end
      PH_RAMP: begin
        // signed division truncates toward zero, as the ramp needs
        span      = longint'(end_cfg) - longint'(start_cfg);
        ramp_step = span * longint'(frame_pos) / longint'(fade_cfg);
        gain      = GAIN_W'(longint'(start_cfg) + ramp_step);
        frame_pos = frame_pos + 1'b1;
      end
      default: begin
        gain   = end_cfg;
        r.done = 1'b1;
      end
    endcase
    r.left  = scale_by_gain(f.left, gain);
    r.right = scale_by_gain(f.right, gain);
    r.gain  = gain;
    return r;
  endfunction

  // input side: offers queued frames, predicts each one on its transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_frames.push_back(fade_gain_predict(pending_frames.pop_front()));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DATA_W'({pending_frames[0].right, pending_frames[0].left});
          s_axis_tuser  <= pending_frames[0].restart;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side ready: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compares every output transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    faded_frame_t got;
    faded_frame_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.left  = m_axis_tdata[SAMPLE_BITS-1:0];
      got.right = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      got.gain  = m_axis_tdata[2*SAMPLE_BITS+GAIN_W-1:2*SAMPLE_BITS];
      got.done  = m_axis_tuser[0];
      if (expected_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected output frame: left %0d right %0d gain %0d done %0b",
                   $signed(got.left), $signed(got.right), got.gain, got.done);
        end
      end else begin
        want = expected_frames.pop_front();
        if (got.left !== want.left || got.right !== want.right ||
            got.gain !== want.gain || got.done !== want.done) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("frame %0d: expected left %0d right %0d gain %0d done %0b",
                     result_count, $signed(want.left), $signed(want.right),
                     want.gain, want.done);
            $display("frame %0d:   actual left %0d right %0d gain %0d done %0b",
                     result_count, $signed(got.left), $signed(got.right),
                     got.gain, got.done);
          end
        end
      end
      result_count++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [1:0] idx, input logic [GAIN_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_GAIN:   start_cfg = value;
      REG_END_GAIN:     end_cfg   = value;
      REG_DELAY_FRAMES: delay_cfg = value;
      REG_FADE_FRAMES:  fade_cfg  = value;
      default: ;
    endcase
  endtask

  task automatic push_frame(input logic signed [SAMPLE_BITS-1:0] l,
                            input logic signed [SAMPLE_BITS-1:0] r, input logic rs);
    stereo_frame_t f;
    f.left    = l;
    f.right   = r;
    f.restart = rs;
    pending_frames.push_back(f);
  endtask

  // stimulus waits until every queued frame is sent and every predicted frame has come back
  task automatic wait_drained();
    while (pending_frames.size() != 0 || s_axis_tvalid || expected_frames.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return SAMPLE_BITS'(int'($urandom_range(4)) - 2);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FIELD_MAX;
      2:       return GAIN_UNITY;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // mostly short lengths so every phase is reached, now and then the extremes
  function automatic logic [GAIN_W-1:0] rand_count(input int short_max);
    case ($urandom_range(19))
      0:       return '0;
      1:       return FIELD_MAX;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(short_max));
    endcase
  endfunction

  initial begin : stimulus
    int frames_left;
    int span;
    int seq_len;
    logic rs;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: zero delay, one ramp frame at unity, then done
    push_frame(SMP_MAX, SMP_MIN, 1'b0);
    push_frame(-1, 1, 1'b0);
    push_frame(0, 12345, 1'b1);
    wait_drained();

    // falling ramp from the top gain: saturation and truncation toward zero
    cfg_write(REG_START_GAIN, FIELD_MAX);
    cfg_write(REG_END_GAIN, '0);
    cfg_write(REG_DELAY_FRAMES, 2);
    cfg_write(REG_FADE_FRAMES, 7);
    push_frame(SMP_MAX, SMP_MIN, 1'b1);
    push_frame(SMP_MIN, SMP_MAX, 1'b0);
    push_frame(-1, 1, 1'b0);
    push_frame(SMP_MAX, -3, 1'b0);
    push_frame(SMP_MIN, 3, 1'b0);
    push_frame(-12345, 2097152, 1'b0);
    push_frame(SMP_MAX, SMP_MIN, 1'b0);
    push_frame(-1, -2, 1'b0);
    push_frame(SMP_MAX, SMP_MIN, 1'b0);
    push_frame(SMP_MIN, SMP_MAX, 1'b0);
    push_frame(5, -5, 1'b0);
    push_frame(SMP_MAX, SMP_MIN, 1'b0);
    wait_drained();

    // zero fade length: straight to end gain
    cfg_write(REG_START_GAIN, '0);
    cfg_write(REG_END_GAIN, FIELD_MAX);
    cfg_write(REG_DELAY_FRAMES, 0);
    cfg_write(REG_FADE_FRAMES, 0);
    push_frame(SMP_MAX, SMP_MIN, 1'b1);
    push_frame(-1, 1, 1'b0);
    push_frame(SMP_MIN, SMP_MAX, 1'b0);
    wait_drained();

    // longest delay and ramp, then both shortened mid-fade
    cfg_write(REG_DELAY_FRAMES, FIELD_MAX);
    cfg_write(REG_FADE_FRAMES, FIELD_MAX);
    push_frame(SMP_MAX, SMP_MIN, 1'b1);
    push_frame(SMP_MIN, SMP_MAX, 1'b0);
    wait_drained();
    cfg_write(REG_DELAY_FRAMES, 0);
    push_frame(SMP_MAX, SMP_MIN, 1'b0);
    push_frame(SMP_MAX, SMP_MIN, 1'b0);
    wait_drained();
    cfg_write(REG_FADE_FRAMES, 1);
    push_frame(SMP_MAX, SMP_MIN, 1'b0);
    push_frame(-1, 1, 1'b0);
    wait_drained();

    // random part: restart-led sequences with random content, some noise
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      cfg_write(REG_START_GAIN, rand_gain());
      cfg_write(REG_END_GAIN, rand_gain());
      cfg_write(REG_DELAY_FRAMES, rand_count(6));
      cfg_write(REG_FADE_FRAMES, rand_count(10));
      frames_left = FRAMES_PER_PHASE;
      while (frames_left > 0) begin
        span    = ((delay_cfg > 16) ? 16 : int'(delay_cfg)) +
                  ((fade_cfg > 16) ? 16 : int'(fade_cfg)) + 4;
        seq_len = $urandom_range(span * 3 / 2, 1);
        for (int i = 0; i < seq_len && frames_left > 0; i++) begin
          rs = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(24) == 0);
          push_frame(rand_sample(), rand_sample(), rs);
          frames_left--;
        end
      end
      // first phase: stall the output long enough to back up the input
      if (ph == 0) begin
        @(posedge clk_i);
        hold_req <= hold_req + 1;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/dlfg_pkg.sv
rtl/core/delayed_linear_fade_gain_top.sv
tb/sv/tb_delayed_linear_fade_gain_top.sv
